[hdl/mctg_pkg.sv]
// Shared types and constants for the MIDI clock transport generator.
`default_nettype none

package mctg_pkg;

    // Input operation codes
    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_TOGGLE = 2'd1,
        OP_CONT   = 2'd2,
        OP_BPM    = 2'd3
    } t_op;

    // MIDI real-time event codes
    typedef enum logic [1:0] {
        EV_CLOCK = 2'd0,
        EV_START = 2'd1,
        EV_STOP  = 2'd2,
        EV_CONT  = 2'd3
    } t_event;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_DIV  = 2'b10
    } t_state;

    localparam int unsigned TEMPO_W   = 9;
    localparam int unsigned TICK_W    = 5;
    localparam int unsigned BEAT_W    = 2;
    localparam int unsigned STEP_W    = 20;
    localparam int unsigned BAR_OUT_W = 16;
    localparam int unsigned DELTA_W   = 4;
    // tempo * 24 tops out at 7200
    localparam int unsigned DVS_W     = 13;

    localparam logic [TICK_W-1:0]  PULSES_PER_BEAT = 5'd24;
    localparam logic [TEMPO_W-1:0] TEMPO_LOW       = 9'd40;
    localparam logic [TEMPO_W-1:0] TEMPO_HIGH      = 9'd300;
    localparam logic [TEMPO_W-1:0] TEMPO_RESET     = 9'd120;
    localparam logic [63:0]        TIME_RESET      = 64'd60000000;
    localparam logic [63:0]        RESET_DIVISOR   = 64'd2880;

    typedef struct packed {
        logic                 busy;
        logic                 done;
    } t_div_status;

endpackage

`default_nettype wire

[hdl/mctg_if.sv]
// Valid/ready channel interfaces for command input and MIDI event output.
`default_nettype none

interface mctg_in_if;
    logic                                        valid;
    logic                                        ready;
    logic [1:0]                                  op;
    logic signed [mctg_pkg::DELTA_W-1:0]         bpm_delta;

    modport source (output valid, output op, output bpm_delta, input ready);
    modport sink   (input valid, input op, input bpm_delta, output ready);
endinterface

interface mctg_out_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          midi_event;
    logic [mctg_pkg::TICK_W-1:0]         tick_position;
    logic [mctg_pkg::BEAT_W-1:0]         beat_position;
    logic [mctg_pkg::BAR_OUT_W-1:0]      bar_count;
    logic [mctg_pkg::STEP_W-1:0]         sixteenth_count;
    logic [mctg_pkg::TEMPO_W-1:0]        tempo_now;

    modport source (output valid, output midi_event, output tick_position,
                    output beat_position, output bar_count, output sixteenth_count,
                    output tempo_now, input ready);
    modport sink   (input valid, input midi_event, input tick_position,
                    input beat_position, input bar_count, input sixteenth_count,
                    input tempo_now, output ready);
endinterface

`default_nettype wire

[hdl/mctg_div.sv]
// Radix-2 restoring divider, one quotient bit per cycle.
`default_nettype none

module mctg_div #(
    parameter int unsigned TIME_WIDTH = 36
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_start,
    input  wire  [TIME_WIDTH-1:0]               i_dividend,
    input  wire  [mctg_pkg::DVS_W-1:0]          i_divisor,
    output mctg_pkg::t_div_status               o_status,
    output logic [TIME_WIDTH-1:0]               o_quotient
);

    localparam int unsigned CNT_W = $clog2(TIME_WIDTH + 1);
    localparam int unsigned DW    = mctg_pkg::DVS_W;

    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic                  r_done, n_done;
    logic [TIME_WIDTH-1:0] r_quo, n_quo;
    logic [DW-1:0]         r_rem, n_rem;
    logic [DW-1:0]         r_dvs, n_dvs;
    logic [DW:0]           rem_sh;
    logic [DW:0]           diff;
    logic                  ge;

    assign rem_sh = {r_rem, r_quo[TIME_WIDTH-1]};
    assign ge     = rem_sh >= {1'b0, r_dvs};
    assign diff   = rem_sh - {1'b0, r_dvs};

    always_comb begin
        n_cnt  = r_cnt;
        n_done = 1'b0;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_cnt = CNT_W'(TIME_WIDTH);
            n_quo = i_dividend;
            n_rem = '0;
            n_dvs = i_divisor;
        end else if (r_cnt != '0) begin
            n_cnt  = r_cnt - 1'b1;
            n_done = (r_cnt == CNT_W'(1));
            n_quo  = {r_quo[TIME_WIDTH-2:0], ge};
            n_rem  = ge ? diff[DW-1:0] : rem_sh[DW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_status   = '{busy: (r_cnt != '0), done: r_done};
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

[hdl/midi_clock_transport_generator.sv]
// Top level: MIDI clock master with transport control and tempo adjust.
// A transaction that emits an event shows it on the output in the cycle after acceptance.
// Throughput: one item per cycle, except a period boundary, which holds off input
// while the divider computes the new period length bit by bit.
// Input is also held off while an output event waits to be taken.
// Reset (synchronous, active low): tempo 120, stopped, position zero, time base 60000000.
`default_nettype none

module midi_clock_transport_generator #(
    parameter int unsigned BAR_WIDTH  = 16,
    parameter int unsigned TIME_WIDTH = 36
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    mctg_in_if.sink               i_in,
    mctg_out_if.source            o_out,
    input  wire                   i_cfg_we,
    input  wire  [TIME_WIDTH-1:0] i_cfg_wdata
);

    localparam int unsigned TW = mctg_pkg::TEMPO_W;
    localparam logic [TIME_WIDTH-1:0] TimeReset   = TIME_WIDTH'(mctg_pkg::TIME_RESET);
    localparam logic [TIME_WIDTH-1:0] PeriodReset =
        TIME_WIDTH'(mctg_pkg::TIME_RESET % (64'd1 << TIME_WIDTH) / mctg_pkg::RESET_DIVISOR);

    mctg_pkg::t_state            r_state, n_state;
    logic [TIME_WIDTH-1:0]       r_time;
    logic [TW-1:0]               r_tempo, n_tempo;
    logic                        r_run, n_run;
    logic [TIME_WIDTH-1:0]       r_elapsed, n_elapsed;
    logic [TIME_WIDTH-1:0]       r_len, n_len;
    logic [mctg_pkg::TICK_W-1:0] r_tick, n_tick;
    logic [mctg_pkg::BEAT_W-1:0] r_beat, n_beat;
    logic [BAR_WIDTH-1:0]        r_bar, n_bar;
    logic [mctg_pkg::STEP_W-1:0] r_step, n_step;
    logic                        r_ovalid, n_ovalid;
    mctg_pkg::t_event            r_event, n_event;

    logic                        accept;
    logic                        div_start;
    mctg_pkg::t_div_status       div_status;
    logic [TIME_WIDTH-1:0]       div_quo;
    logic [mctg_pkg::DVS_W-1:0]  divisor;
    logic [TIME_WIDTH-1:0]       elapsed_inc;
    logic [mctg_pkg::TICK_W-1:0] tick_inc;
    logic signed [TW+1:0]        tempo_sum;
    logic [BAR_WIDTH+15:0]       bar_ext;

    assign i_in.ready  = (r_state == mctg_pkg::S_IDLE) && (!r_ovalid || o_out.ready);
    assign accept      = i_in.valid && i_in.ready;
    assign divisor     = mctg_pkg::DVS_W'(r_tempo * 13'd24);
    assign elapsed_inc = r_elapsed + 1'b1;
    assign tick_inc    = r_tick + 1'b1;
    assign tempo_sum   = $signed({2'b00, r_tempo}) + (TW+2)'(i_in.bpm_delta);

    always_comb begin
        n_state   = r_state;
        n_tempo   = r_tempo;
        n_run     = r_run;
        n_elapsed = r_elapsed;
        n_len     = r_len;
        n_tick    = r_tick;
        n_beat    = r_beat;
        n_bar     = r_bar;
        n_step    = r_step;
        n_ovalid  = r_ovalid && !o_out.ready;
        n_event   = r_event;
        div_start = 1'b0;

        unique case (r_state)
            mctg_pkg::S_IDLE: begin
                if (accept) begin
                    case (mctg_pkg::t_op'(i_in.op))
                        mctg_pkg::OP_TICK: begin
                            n_elapsed = elapsed_inc;
                            if (elapsed_inc >= r_len) begin
                                // period boundary: restart and relatch length
                                n_elapsed = '0;
                                div_start = 1'b1;
                                n_state   = mctg_pkg::S_DIV;
                                if (r_run) begin
                                    n_tick = tick_inc;
                                    if (tick_inc == 5'd6 || tick_inc == 5'd12 ||
                                        tick_inc == 5'd18 || tick_inc == 5'd24)
                                        n_step = r_step + 1'b1;
                                    if (tick_inc >= mctg_pkg::PULSES_PER_BEAT) begin
                                        n_tick = '0;
                                        n_beat = r_beat + 1'b1;
                                        if (r_beat == 2'd3)
                                            n_bar = r_bar + 1'b1;
                                    end
                                    n_ovalid = 1'b1;
                                    n_event  = mctg_pkg::EV_CLOCK;
                                end
                            end
                        end
                        mctg_pkg::OP_TOGGLE: begin
                            n_ovalid = 1'b1;
                            if (r_run) begin
                                n_run   = 1'b0;
                                n_event = mctg_pkg::EV_STOP;
                            end else begin
                                n_run   = 1'b1;
                                n_tick  = '0;
                                n_beat  = '0;
                                n_bar   = '0;
                                n_step  = '0;
                                n_event = mctg_pkg::EV_START;
                            end
                        end
                        mctg_pkg::OP_CONT: begin
                            if (!r_run) begin
                                n_run    = 1'b1;
                                n_ovalid = 1'b1;
                                n_event  = mctg_pkg::EV_CONT;
                            end
                        end
                        default: begin
                            if (tempo_sum < $signed({2'b00, mctg_pkg::TEMPO_LOW}))
                                n_tempo = mctg_pkg::TEMPO_LOW;
                            else if (tempo_sum > $signed({2'b00, mctg_pkg::TEMPO_HIGH}))
                                n_tempo = mctg_pkg::TEMPO_HIGH;
                            else
                                n_tempo = tempo_sum[TW-1:0];
                        end
                    endcase
                end
            end
            mctg_pkg::S_DIV: begin
                if (div_status.done) begin
                    n_len   = div_quo;
                    n_state = mctg_pkg::S_IDLE;
                end
            end
            default: n_state = mctg_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= mctg_pkg::S_IDLE;
            r_time    <= TimeReset;
            r_tempo   <= mctg_pkg::TEMPO_RESET;
            r_run     <= 1'b0;
            r_elapsed <= '0;
            r_len     <= PeriodReset;
            r_tick    <= '0;
            r_beat    <= '0;
            r_bar     <= '0;
            r_step    <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            if (i_cfg_we)
                r_time <= i_cfg_wdata;
            r_tempo   <= n_tempo;
            r_run     <= n_run;
            r_elapsed <= n_elapsed;
            r_len     <= n_len;
            r_tick    <= n_tick;
            r_beat    <= n_beat;
            r_bar     <= n_bar;
            r_step    <= n_step;
            r_ovalid  <= n_ovalid;
        end
        r_event <= n_event;
    end

    mctg_div #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_time),
        .i_divisor  (divisor),
        .o_status   (div_status),
        .o_quotient (div_quo)
    );

    // position fields are live registers; they only move when a new transaction is taken
    assign bar_ext               = {16'b0, r_bar};
    assign o_out.valid           = r_ovalid;
    assign o_out.midi_event      = r_event;
    assign o_out.tick_position   = r_tick;
    assign o_out.beat_position   = r_beat;
    assign o_out.bar_count       = bar_ext[mctg_pkg::BAR_OUT_W-1:0];
    assign o_out.sixteenth_count = r_step;
    assign o_out.tempo_now       = r_tempo;

endmodule

`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench for the MIDI clock transport generator: predicted event stream vs. DUT.
`timescale 1ns / 1ps

module tb_top;

    localparam int unsigned TIME_W        = 36;
    localparam int unsigned TICK_W        = mctg_pkg::TICK_W;
    localparam int unsigned BEAT_W        = mctg_pkg::BEAT_W;
    localparam int unsigned BAR_OUT_W     = mctg_pkg::BAR_OUT_W;
    localparam int unsigned STEP_W        = mctg_pkg::STEP_W;
    localparam int unsigned TEMPO_W       = mctg_pkg::TEMPO_W;
    localparam int unsigned DELTA_W       = mctg_pkg::DELTA_W;
    localparam int unsigned WARMUP_TICKS  = 20833;
    localparam int unsigned PHASE_ITEMS   = 100;
    localparam int unsigned NUM_PHASES    = 7;
    localparam int unsigned SETTLE_CYCLES = 48;
    localparam int unsigned LONG_HOLD     = 300;
    localparam int unsigned CYCLE_LIMIT   = 800000;
    localparam logic [TIME_W-1:0] TIME_MIN = 36'd2880;
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    typedef struct packed {
        mctg_pkg::t_event     ev;
        logic [TICK_W-1:0]    tick;
        logic [BEAT_W-1:0]    beat;
        logic [BAR_OUT_W-1:0] bar;
        logic [STEP_W-1:0]    step;
        logic [TEMPO_W-1:0]   tempo;
    } t_midi_msg;

    class transport_scoreboard;
        logic [TIME_W-1:0]    time_base;
        logic [TEMPO_W-1:0]   tempo;
        bit                   running;
        logic [TIME_W-1:0]    elapsed;
        logic [TIME_W-1:0]    period_len;
        logic [TICK_W-1:0]    tick;
        logic [BEAT_W-1:0]    beat;
        logic [BAR_OUT_W-1:0] bar;
        logic [STEP_W-1:0]    step;
        t_midi_msg            pending_events[$];
        int                   errors;

        function new();
            errors     = 0;
            time_base  = TIME_W'(mctg_pkg::TIME_RESET);
            tempo      = mctg_pkg::TEMPO_RESET;
            running    = 1'b0;
            elapsed    = '0;
            period_len = period_for_tempo();
            clear_position();
        endfunction

        function logic [TIME_W-1:0] period_for_tempo();
            return time_base / (TIME_W'(tempo) * TIME_W'(mctg_pkg::PULSES_PER_BEAT));
        endfunction

        function void clear_position();
            tick = '0;
            beat = '0;
            bar  = '0;
            step = '0;
        endfunction

        function void push_event(mctg_pkg::t_event ev);
            pending_events.push_back('{ev, tick, beat, bar, step, tempo});
        endfunction

        // Predict the effect of one accepted input transaction.
        function void note_input(mctg_pkg::t_op op, logic signed [DELTA_W-1:0] delta);
            int t;
            case (op)
                mctg_pkg::OP_TICK: begin
                    elapsed = elapsed + 1'b1;
                    if (elapsed >= period_len) begin
                        elapsed    = '0;
                        period_len = period_for_tempo();
                        if (running) begin
                            tick = tick + 1'b1;
                            if (tick % 6 == 0)
                                step = step + 1'b1;
                            if (tick >= mctg_pkg::PULSES_PER_BEAT) begin
                                tick = '0;
                                if (beat == 2'd3) begin
                                    beat = '0;
                                    bar  = bar + 1'b1;
                                end else begin
                                    beat = beat + 1'b1;
                                end
                            end
                            push_event(mctg_pkg::EV_CLOCK);
                        end
                    end
                end
                mctg_pkg::OP_TOGGLE: begin
                    if (running) begin
                        running = 1'b0;
                        push_event(mctg_pkg::EV_STOP);
                    end else begin
                        clear_position();
                        running = 1'b1;
                        push_event(mctg_pkg::EV_START);
                    end
                end
                mctg_pkg::OP_CONT: begin
                    if (!running) begin
                        running = 1'b1;
                        push_event(mctg_pkg::EV_CONT);
                    end
                end
                default: begin
                    t = int'(tempo) + int'(delta);
                    if (t < int'(mctg_pkg::TEMPO_LOW))
                        t = int'(mctg_pkg::TEMPO_LOW);
                    if (t > int'(mctg_pkg::TEMPO_HIGH))
                        t = int'(mctg_pkg::TEMPO_HIGH);
                    tempo = TEMPO_W'(t);
                end
            endcase
        endfunction

        function void check_result(t_midi_msg got);
            t_midi_msg want;
            if (pending_events.size() == 0) begin
                $error("unexpected MIDI event %0d", got.ev);
                errors++;
                return;
            end
            want = pending_events.pop_front();
            if (got.ev !== want.ev) begin
                $error("midi_event: expected %0d, actual %0d", want.ev, got.ev);
                errors++;
            end
            if (got.tick !== want.tick) begin
                $error("tick_position: expected %0d, actual %0d", want.tick, got.tick);
                errors++;
            end
            if (got.beat !== want.beat) begin
                $error("beat_position: expected %0d, actual %0d", want.beat, got.beat);
                errors++;
            end
            if (got.bar !== want.bar) begin
                $error("bar_count: expected %0d, actual %0d", want.bar, got.bar);
                errors++;
            end
            if (got.step !== want.step) begin
                $error("sixteenth_count: expected %0d, actual %0d", want.step, got.step);
                errors++;
            end
            if (got.tempo !== want.tempo) begin
                $error("tempo_now: expected %0d, actual %0d", want.tempo, got.tempo);
                errors++;
            end
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_we;
    logic [TIME_W-1:0] cfg_wdata;
    int unsigned       cyc = 0;
    int unsigned       event_count = 0;
    bit                gaps_off = 1'b0;

    transport_scoreboard sb = new();

    mctg_in_if  in_if ();
    mctg_out_if out_if ();

    midi_clock_transport_generator #(
        .BAR_WIDTH  (16),
        .TIME_WIDTH (TIME_W)
    ) u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in        (in_if),
        .o_out       (out_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    always #4 clk = ~clk;

    always @(posedge clk) begin
        cyc <= cyc + 1;
        if (cyc == CYCLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    function automatic int any_delta();
        return int'($urandom_range(15)) - 8;
    endfunction

    task automatic send_cmd(input mctg_pkg::t_op op, input int delta);
        while (!gaps_off && $urandom_range(99) < 8) begin
            in_if.valid <= 1'b0;
            @(posedge clk);
        end
        in_if.valid     <= 1'b1;
        in_if.op        <= op;
        in_if.bpm_delta <= DELTA_W'(delta);
        @(posedge clk);
        while (!in_if.ready)
            @(posedge clk);
        sb.note_input(op, DELTA_W'(delta));
    endtask

    // Lets every predicted event drain, then covers a divide started by a silent boundary.
    task automatic wait_for_drain();
        in_if.valid <= 1'b0;
        while (sb.pending_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_time_base(input logic [TIME_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we       <= 1'b0;
        sb.time_base  = value;
    endtask

    // Runs with the shortest time base: period length 1 at tempo 120.
    task automatic directed_checks();
        send_cmd(mctg_pkg::OP_TICK, 0);
        send_cmd(mctg_pkg::OP_TOGGLE, 7);   // stop keeps position
        send_cmd(mctg_pkg::OP_TICK, -8);    // boundary while stopped
        send_cmd(mctg_pkg::OP_CONT, 0);
        send_cmd(mctg_pkg::OP_CONT, 3);     // ignored while running
        send_cmd(mctg_pkg::OP_BPM, 7);      // 127 bpm: next latch gives a zero-length period
        repeat (3) send_cmd(mctg_pkg::OP_TICK, 0);
        send_cmd(mctg_pkg::OP_BPM, -8);
        send_cmd(mctg_pkg::OP_BPM, 0);
        send_cmd(mctg_pkg::OP_BPM, -1);
        send_cmd(mctg_pkg::OP_BPM, 5);
        send_cmd(mctg_pkg::OP_BPM, -5);
        send_cmd(mctg_pkg::OP_TOGGLE, 0);
        send_cmd(mctg_pkg::OP_TOGGLE, 0);   // start clears position
        repeat (6) send_cmd(mctg_pkg::OP_TICK, -1);
    endtask

    initial begin : stimulus
        int unsigned       burst_left;
        bit                burst_up;
        int unsigned       pick;
        int unsigned       item_no;
        logic [TIME_W-1:0] tb_val;
        burst_left = 0;
        burst_up   = 1'b0;
        item_no    = 0;
        rst_n           <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_wdata       <= '0;
        in_if.valid     <= 1'b0;
        in_if.op        <= mctg_pkg::OP_TICK;
        in_if.bpm_delta <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        wait_for_drain();
        write_time_base(TIME_MIN);

        // The reset period length only changes at a boundary, so run it out once.
        send_cmd(mctg_pkg::OP_TOGGLE, any_delta());
        repeat (WARMUP_TICKS) send_cmd(mctg_pkg::OP_TICK, any_delta());
        directed_checks();
        wait_for_drain();

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0, 3:    tb_val = TIME_MIN;
                1:       tb_val = TIME_W'($urandom_range(8000, 2881));
                2:       tb_val = TIME_W'($urandom_range(40000, 8000));
                4:       tb_val = TIME_W'($urandom_range(200000, 100000));
                default: tb_val = TIME_W'($urandom_range(20000, 2880));
            endcase
            write_time_base(tb_val);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                gaps_off = (item_no >= 300 && item_no < 400);
                item_no++;
                if (burst_left > 0) begin
                    // tempo sweep toward one of the clamps
                    burst_left--;
                    if (burst_up)
                        send_cmd(mctg_pkg::OP_BPM, int'($urandom_range(7, 1)));
                    else
                        send_cmd(mctg_pkg::OP_BPM, -int'($urandom_range(8, 1)));
                end else begin
                    pick = $urandom_range(99);
                    if (pick < 3) begin
                        burst_left = $urandom_range(45, 20);
                        burst_up   = 1'($urandom_range(1));
                        send_cmd(mctg_pkg::OP_TICK, any_delta());
                    end else if (pick < 80) begin
                        send_cmd(mctg_pkg::OP_TICK, any_delta());
                    end else if (pick < 86) begin
                        send_cmd(mctg_pkg::OP_TOGGLE, any_delta());
                    end else if (pick < 92) begin
                        send_cmd(mctg_pkg::OP_CONT, any_delta());
                    end else begin
                        send_cmd(mctg_pkg::OP_BPM, any_delta());
                    end
                end
            end
            gaps_off = 1'b0;
            wait_for_drain();
        end

        // Largest time base: only the latch at the next boundary is visible.
        write_time_base(TIME_MAX);
        repeat (300) send_cmd(mctg_pkg::OP_TICK, any_delta());
        wait_for_drain();

        if (sb.errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    initial begin : event_sink
        int unsigned hold_left;
        bit          hold_done;
        t_midi_msg   got;
        hold_left = 0;
        hold_done = 1'b0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && out_if.valid && out_if.ready) begin
                got.ev    = mctg_pkg::t_event'(out_if.midi_event);
                got.tick  = out_if.tick_position;
                got.beat  = out_if.beat_position;
                got.bar   = out_if.bar_count;
                got.step  = out_if.sixteenth_count;
                got.tempo = out_if.tempo_now;
                sb.check_result(got);
                event_count++;
            end
            // one long back-pressure stretch while commands keep coming
            if (!hold_done && event_count >= 100 && in_if.valid) begin
                hold_left = LONG_HOLD;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else if (event_count >= 200 && event_count < 350) begin
                out_if.ready <= 1'b1;
            end else begin
                out_if.ready <= ($urandom_range(99) >= 8);
            end
        end
    end

endmodule
